// File: rtl/pidat_pkg.sv
// Package for the PNG IDAT extractor: word types of the two channels and
// the chunk-format constants. No dependencies.
package pidat_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TOTAL_W  = 32;
	localparam int unsigned LEN_W    = 31;
	localparam int unsigned TYPE_W   = 32;

	localparam logic [TYPE_W-1:0] TYPE_IDAT = 32'h4944_4154;
	localparam logic [TYPE_W-1:0] TYPE_IEND = 32'h4945_4E44;

	localparam int unsigned SIG_BYTES   = 8;
	localparam int unsigned FIELD_BYTES = 4;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               is_payload;
		logic               is_done;
		logic [TOTAL_W-1:0] total_length;
		logic               seq_error;
	} out_word_t;

	// One step of the chunk walker: whether it produced a word, and which.
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} step_res_t;

	// Walker status seen by the top level.
	typedef struct packed {
		logic stopped;
		logic in_data;
	} walk_stat_t;

endpackage

// File: rtl/pidat_stream_if.sv
// Valid/ready stream interface carrying one word of a packed payload type.
// Payload types come from pidat_pkg at the point of instantiation.
interface pidat_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/png_idat_chunk_extractor.sv
// Top level of the PNG IDAT extractor: chunk walker plus a two-word output
// buffer. Depends on pidat_pkg, pidat_stream_if and pidat_walker.
//
//   channel   dir  word                     notes
//   bytes     in   in_word_t (data_byte)    one file byte per word
//   results   out  out_word_t               payload byte, done or error word
//
// Each accepted byte's result, if any, is registered; a byte can follow in
// every cycle while bytes.ready is high. The output register has a skid word
// behind it, so bytes keep flowing while one result waits; bytes.ready drops
// only when both are full. Reset clears the parse state and the buffer's valid
// flags. After the done or error word, bytes are still taken and dropped.
module png_idat_chunk_extractor (
	input  logic                  clk,
	input  logic                  arst_n,
	pidat_stream_if.sink          bytes,
	pidat_stream_if.source        results
);

	pidat_pkg::step_res_t   res;
	pidat_pkg::walk_stat_t  stat;
	logic                   take;
	logic                   out_valid_q, skid_valid_q;
	pidat_pkg::out_word_t   out_q, skid_q;

	assign bytes.ready = !skid_valid_q;
	assign take        = bytes.valid && bytes.ready;

	pidat_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.data_byte (bytes.data.data_byte),
		.res       (res),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (results.ready) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && !results.ready) begin
			skid_valid_q <= res.valid;
		end else begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (results.ready) begin
				out_q <= skid_q;
			end
		end else if (out_valid_q && !results.ready) begin
			skid_q <= res.word;
		end else begin
			out_q <= res.word;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// The skid word is only ever filled behind a waiting output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word valid with empty output register");

	// Once IEND or a broken IDAT run has been seen, no more words appear.
	a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		stat.stopped |-> !res.valid)
		else $error("result produced after the walk stopped");

	// A result is exactly one of payload, done or error.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> $onehot({results.data.is_payload, results.data.is_done,
			results.data.seq_error}))
		else $error("result word carries no kind or several kinds");

	// Payload bytes come only out of the data phase of a chunk.
	a_payload_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.word.is_payload |-> stat.in_data)
		else $error("payload byte outside a chunk body");

endmodule

// File: rtl/pidat_walker.sv
// Chunk walker of the PNG IDAT extractor: holds the parse state and works out
// the result of one accepted byte in the same cycle. Depends on pidat_pkg.
module pidat_walker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [pidat_pkg::BYTE_W-1:0]      data_byte,
	output pidat_pkg::step_res_t              res,
	output pidat_pkg::walk_stat_t             stat
);

	typedef enum logic [6:0] {
		PH_SIG  = 7'b000_0001,
		PH_LEN  = 7'b000_0010,
		PH_TYPE = 7'b000_0100,
		PH_DATA = 7'b000_1000,
		PH_CRC  = 7'b001_0000,
		PH_DONE = 7'b010_0000,
		PH_HALT = 7'b100_0000
	} phase_t;

	localparam logic [1:0] IDAT_NONE   = 2'd0;
	localparam logic [1:0] IDAT_RUN    = 2'd1;
	localparam logic [1:0] IDAT_BROKEN = 2'd2;

	phase_t                             phase_q, phase_n;
	logic [pidat_pkg::LEN_W-1:0]        cnt_q, cnt_n, cnt_inc;
	logic [pidat_pkg::LEN_W-1:0]        len_q, len_n;
	logic [pidat_pkg::TYPE_W-1:0]       type_q, type_n;
	logic [1:0]                         prog_q, prog_n;
	logic [pidat_pkg::TOTAL_W-1:0]      sum_q, sum_n;
	logic [pidat_pkg::TOTAL_W:0]        sum_wide;

	assign cnt_inc  = cnt_q + 1'b1;
	assign sum_wide = {1'b0, sum_q} + {2'b00, len_q};

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		type_n  = type_q;
		prog_n  = prog_q;
		sum_n   = sum_q;
		res     = '0;
		case (phase_q)
			PH_SIG: begin
				cnt_n = cnt_inc;
				if (cnt_inc >= pidat_pkg::LEN_W'(pidat_pkg::SIG_BYTES)) begin
					cnt_n   = '0;
					len_n   = '0;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				// Bit 31 of the length field falls off the top here.
				len_n = {len_q[pidat_pkg::LEN_W-pidat_pkg::BYTE_W-1:0], data_byte};
				cnt_n = cnt_inc;
				if (cnt_inc >= pidat_pkg::LEN_W'(pidat_pkg::FIELD_BYTES)) begin
					cnt_n   = '0;
					type_n  = '0;
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_n = {type_q[pidat_pkg::TYPE_W-pidat_pkg::BYTE_W-1:0], data_byte};
				cnt_n  = cnt_inc;
				if (cnt_inc >= pidat_pkg::LEN_W'(pidat_pkg::FIELD_BYTES)) begin
					cnt_n = '0;
					if (type_n == pidat_pkg::TYPE_IEND) begin
						phase_n                = PH_DONE;
						res.valid              = 1'b1;
						res.word.is_done       = 1'b1;
						res.word.total_length  = sum_q;
					end else if (type_n == pidat_pkg::TYPE_IDAT &&
						prog_q == IDAT_BROKEN) begin
						phase_n             = PH_HALT;
						res.valid           = 1'b1;
						res.word.seq_error  = 1'b1;
					end else begin
						if (type_n == pidat_pkg::TYPE_IDAT) begin
							prog_n = IDAT_RUN;
							sum_n  = sum_wide[pidat_pkg::TOTAL_W] ? '1 :
								sum_wide[pidat_pkg::TOTAL_W-1:0];
						end else if (prog_q == IDAT_RUN) begin
							prog_n = IDAT_BROKEN;
						end
						phase_n = (len_q == '0) ? PH_CRC : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				cnt_n = cnt_inc;
				if (cnt_inc >= len_q) begin
					cnt_n   = '0;
					phase_n = PH_CRC;
				end
				if (type_q == pidat_pkg::TYPE_IDAT) begin
					res.valid           = 1'b1;
					res.word.out_byte   = data_byte;
					res.word.is_payload = 1'b1;
				end
			end
			PH_CRC: begin
				cnt_n = cnt_inc;
				if (cnt_inc >= pidat_pkg::LEN_W'(pidat_pkg::FIELD_BYTES)) begin
					cnt_n   = '0;
					len_n   = '0;
					phase_n = PH_LEN;
				end
			end
			default: begin
			end
		endcase
		if (!step) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			cnt_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			prog_q  <= IDAT_NONE;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			type_q  <= type_n;
			prog_q  <= prog_n;
			sum_q   <= sum_n;
		end
	end

	assign stat.stopped = (phase_q != PH_SIG) && (phase_q != PH_LEN) &&
		(phase_q != PH_TYPE) && (phase_q != PH_DATA) && (phase_q != PH_CRC);
	assign stat.in_data = (phase_q == PH_DATA);

endmodule

// File: sim/tb.sv
// Self-checking testbench for png_idat_chunk_extractor. It feeds one PNG-like byte
// stream and checks every result word against a predictor of the chunk walker.
// Depends on pidat_pkg, pidat_stream_if and the RTL of the block.
module tb;

	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned HOLD_CYCLES = 64;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned IDAT_RUN_BYTES = 1700;
	localparam int unsigned HOLD_AFTER_PAYLOAD = 150;

	localparam logic [pidat_pkg::TYPE_W-1:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [pidat_pkg::TYPE_W-1:0] TYPE_TEXT = 32'h7445_5874;

	typedef enum logic [2:0] {
		ST_SIG, ST_LEN, ST_TYPE, ST_DATA, ST_CRC, ST_DONE, ST_HALT
	} walk_stage_t;

	typedef enum logic [1:0] {
		RUN_NONE, RUN_OPEN, RUN_CLOSED
	} idat_run_t;

	// Tracks the chunk walk byte by byte and holds the result words still owed.
	class idat_scoreboard_t;
		walk_stage_t                       stage;
		logic [31:0]                       field_cnt;
		logic [pidat_pkg::LEN_W-1:0]       chunk_len;
		logic [pidat_pkg::TYPE_W-1:0]      chunk_kind;
		idat_run_t                         idat_run;
		logic [pidat_pkg::TOTAL_W-1:0]     idat_total;
		pidat_pkg::out_word_t              owed_words[$];
		int unsigned                       mismatches;
		int unsigned                       payload_count;
		int unsigned                       done_count;
		int unsigned                       error_count;

		function new();
			stage = ST_SIG;
			field_cnt = '0;
			chunk_len = '0;
			chunk_kind = '0;
			idat_run = RUN_NONE;
			idat_total = '0;
			mismatches = 0;
			payload_count = 0;
			done_count = 0;
			error_count = 0;
		endfunction

		function void note_byte(logic [pidat_pkg::BYTE_W-1:0] b);
			pidat_pkg::out_word_t w;
			w = '0;
			case (stage)
				ST_SIG: begin
					field_cnt++;
					if (field_cnt >= pidat_pkg::SIG_BYTES) begin
						field_cnt = '0;
						chunk_len = '0;
						stage = ST_LEN;
					end
				end
				ST_LEN: begin
					// Only the low 31 bits of the length survive the shift.
					chunk_len = {chunk_len[pidat_pkg::LEN_W-9:0], b};
					field_cnt++;
					if (field_cnt >= pidat_pkg::FIELD_BYTES) begin
						field_cnt = '0;
						chunk_kind = '0;
						stage = ST_TYPE;
					end
				end
				ST_TYPE: begin
					chunk_kind = {chunk_kind[pidat_pkg::TYPE_W-9:0], b};
					field_cnt++;
					if (field_cnt >= pidat_pkg::FIELD_BYTES) begin
						field_cnt = '0;
						if (chunk_kind == pidat_pkg::TYPE_IEND) begin
							stage = ST_DONE;
							w.is_done = 1'b1;
							w.total_length = idat_total;
							owed_words.push_back(w);
						end else if (chunk_kind == pidat_pkg::TYPE_IDAT &&
							idat_run == RUN_CLOSED) begin
							stage = ST_HALT;
							w.seq_error = 1'b1;
							owed_words.push_back(w);
						end else begin
							if (chunk_kind == pidat_pkg::TYPE_IDAT) begin
								idat_run = RUN_OPEN;
								if (idat_total > (32'hFFFF_FFFF - {1'b0, chunk_len}))
									idat_total = '1;
								else
									idat_total += {1'b0, chunk_len};
							end else if (idat_run == RUN_OPEN) begin
								idat_run = RUN_CLOSED;
							end
							stage = (chunk_len == '0) ? ST_CRC : ST_DATA;
						end
					end
				end
				ST_DATA: begin
					field_cnt++;
					if (field_cnt >= {1'b0, chunk_len}) begin
						field_cnt = '0;
						stage = ST_CRC;
					end
					if (chunk_kind == pidat_pkg::TYPE_IDAT) begin
						w.out_byte = b;
						w.is_payload = 1'b1;
						owed_words.push_back(w);
					end
				end
				ST_CRC: begin
					field_cnt++;
					if (field_cnt >= pidat_pkg::FIELD_BYTES) begin
						field_cnt = '0;
						chunk_len = '0;
						stage = ST_LEN;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_result(pidat_pkg::out_word_t got);
			pidat_pkg::out_word_t want;
			bit ok;
			if (owed_words.size() == 0) begin
				$display("%0t: result word with none expected, expected nothing, actual %p",
					$time, got);
				mismatches++;
				return;
			end
			want = owed_words.pop_front();
			ok = field_ok("out_byte", 32'(want.out_byte), 32'(got.out_byte));
			ok &= field_ok("is_payload", 32'(want.is_payload), 32'(got.is_payload));
			ok &= field_ok("is_done", 32'(want.is_done), 32'(got.is_done));
			ok &= field_ok("total_length", want.total_length, got.total_length);
			ok &= field_ok("seq_error", 32'(want.seq_error), 32'(got.seq_error));
			if (!ok)
				mismatches++;
			if (want.is_payload)
				payload_count++;
			if (want.is_done)
				done_count++;
			if (want.seq_error)
				error_count++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	logic [pidat_pkg::BYTE_W-1:0] png_stream[$];
	bit hold_active = 1'b0;
	bit hold_done = 1'b0;
	bit quiet_tail = 1'b0;
	bit end_with_error;
	idat_scoreboard_t sb = new();

	pidat_stream_if #(.payload_t(pidat_pkg::in_word_t)) byte_ch ();
	pidat_stream_if #(.payload_t(pidat_pkg::out_word_t)) result_ch ();

	png_idat_chunk_extractor i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_ch),
		.results(result_ch)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("png_idat_chunk_extractor verification failed");
			$finish;
		end
	end

	// Bytes are noted before results are checked, so a word can never be
	// checked ahead of the byte that caused it.
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready)
			sb.note_byte(byte_ch.data.data_byte);
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.data);
	end

	function automatic logic [pidat_pkg::BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'hFF;
			default: return pidat_pkg::BYTE_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_len();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(100, 300);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	// Any chunk type but IDAT and IEND, with near misses of both.
	function automatic logic [pidat_pkg::TYPE_W-1:0] other_type();
		logic [pidat_pkg::TYPE_W-1:0] t;
		case ($urandom_range(0, 4))
			0: t = TYPE_IHDR;
			1: t = TYPE_TEXT;
			2: t = pidat_pkg::TYPE_IDAT ^ (32'h1 << $urandom_range(0, 31));
			3: t = pidat_pkg::TYPE_IEND ^ (32'h1 << $urandom_range(0, 31));
			default: t = $urandom;
		endcase
		if (t == pidat_pkg::TYPE_IDAT || t == pidat_pkg::TYPE_IEND)
			t ^= 32'h0000_0100;
		return t;
	endfunction

	// Appends one chunk; the length top bit is set now and then, since it is ignored.
	task automatic add_chunk(logic [pidat_pkg::TYPE_W-1:0] kind, int unsigned len);
		logic [31:0] len_field;
		len_field = {($urandom_range(0, 5) == 0), 31'(len)};
		for (int k = 3; k >= 0; k--)
			png_stream.push_back(len_field[8*k +: 8]);
		for (int k = 3; k >= 0; k--)
			png_stream.push_back(kind[8*k +: 8]);
		repeat (len)
			png_stream.push_back(rand_byte());
		repeat (pidat_pkg::FIELD_BYTES)
			png_stream.push_back(rand_byte());
	endtask

	task automatic build_stream();
		logic [pidat_pkg::BYTE_W-1:0] sig[8] =
			'{8'hFF, 8'h00, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
		foreach (sig[k])
			png_stream.push_back(sig[k]);
		// Zero-length near-miss of IDAT whose length carries only the top bit.
		png_stream.push_back(8'h80);
		repeat (3)
			png_stream.push_back(8'h00);
		for (int k = 3; k >= 0; k--)
			png_stream.push_back(8'(pidat_pkg::TYPE_IDAT[8*k +: 8] ^ (k == 0)));
		repeat (pidat_pkg::FIELD_BYTES)
			png_stream.push_back(8'hFF);
		repeat ($urandom_range(0, 2))
			add_chunk(other_type(), $urandom_range(0, 24));
		add_chunk(pidat_pkg::TYPE_IDAT, 0);
		while (png_stream.size() < IDAT_RUN_BYTES)
			add_chunk(pidat_pkg::TYPE_IDAT, pick_len());
		repeat ($urandom_range(1, 3))
			add_chunk(other_type(), $urandom_range(0, 24));
		// One run ends on IEND, another on a broken IDAT run; what follows is ignored.
		end_with_error = $urandom_range(0, 1);
		if (end_with_error) begin
			add_chunk(pidat_pkg::TYPE_IDAT, $urandom_range(0, 8));
			add_chunk(pidat_pkg::TYPE_IEND, 0);
		end else begin
			add_chunk(pidat_pkg::TYPE_IEND, $urandom_range(0, 8));
			add_chunk(pidat_pkg::TYPE_IDAT, 4);
		end
	endtask

	task automatic send_file();
		int unsigned tail_start;
		tail_start = png_stream.size() * 85 / 100;
		foreach (png_stream[i]) begin
			if (i >= tail_start)
				quiet_tail = 1'b1;
			if (!quiet_tail && !hold_active && $urandom_range(0, 5) == 0) begin
				byte_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			byte_ch.valid <= 1'b1;
			byte_ch.data.data_byte <= png_stream[i];
			@(posedge clk);
			while (!byte_ch.ready)
				@(posedge clk);
		end
		byte_ch.valid <= 1'b0;
	endtask

	task automatic receive_results();
		forever begin
			if (!hold_done && sb.payload_count >= HOLD_AFTER_PAYLOAD) begin
				// Long back-pressure so the output buffer fills and the byte input stalls.
				result_ch.ready <= 1'b0;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				hold_done = 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data = '0;
		result_ch.ready = 1'b0;
		build_stream();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		fork
			receive_results();
		join_none
		send_file();
		while (sb.owed_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Fed %0d file bytes; checked %0d IDAT payload words, %0d done and %0d error words.",
			png_stream.size(), sb.payload_count, sb.done_count, sb.error_count);
		$display("Stream ended on %s, with bytes after it that the block must drop.",
			end_with_error ? "a broken IDAT run" : "an IEND chunk");
		if (sb.mismatches == 0) begin
			$display("png_idat_chunk_extractor verification clean");
		end else begin
			$display("png_idat_chunk_extractor verification failed");
		end
		$finish;
	end
endmodule
